// ----- src/swpp_pkg.sv -----
// Shared types and constants of the spatial pattern width predictor.
package swpp_pkg;

	localparam int ADDR_W    = 48;
	localparam int OFF_W     = 12;
	localparam int SB_W      = 6;
	localparam int CNT_W     = 6;
	localparam int N_W       = 7;
	localparam int PAT_W     = 64;
	localparam int KEY_W     = ADDR_W + OFF_W;
	localparam int IDX_SHIFT = 2;
	localparam int HIST_ENTRIES = 1024;
	localparam int HIST_AW   = $clog2(HIST_ENTRIES);
	localparam int MAX_SB    = 64;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_AW    = 4;

	typedef enum logic [1:0] {
		MODE_PREDICT = 2'd0,
		MODE_RECORD  = 2'd1,
		MODE_COMMIT  = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OUT_DONE  = 2'd0,
		OUT_FULL  = 2'd1,
		OUT_NOREC = 2'd2,
		OUT_RSVD  = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		REG_SUBBLOCKS = 2'd0,
		REG_FB_LEFT   = 2'd1,
		REG_FB_RIGHT  = 2'd2,
		REG_RUN_RULE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [N_W-1:0]   subblocks_in_use;
		logic [CNT_W-1:0] fallback_left;
		logic [CNT_W-1:0] fallback_right;
		logic             run_rule;
	} cfg_t;

	typedef struct packed {
		logic clear_step;
		logic load_in;
		logic mem_rd;
		logic setup;
		logic walk;
		logic exec;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic mode_predict;
		logic usable;
		logic walk_done;
	} status_t;

endpackage

// ----- src/swpp_ctrl.sv -----
// Controller state machine of the spatial pattern width predictor.
module swpp_ctrl import swpp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_SETUP = 7'b0001000,
		ST_WALK  = 7'b0010000,
		ST_EXEC  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_d = status.mode_predict ? ST_SETUP : ST_EXEC;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d = status.usable ? ST_WALK : ST_DONE;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_done) state_d = ST_DONE;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/swpp_dp.sv -----
// Datapath: history memory, record table, run walkers and result registers.
module swpp_dp import swpp_pkg::*; #(
	parameter int RECORD_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  cfg_t                  cfg,
	input  logic [1:0]            in_mode,
	input  logic [IN_DATA_W-1:0]  in_data,
	output status_t               status,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int RW = (RECORD_ENTRIES > 1) ? $clog2(RECORD_ENTRIES) : 1;

	// Input word registers.
	logic [1:0]        mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [OFF_W-1:0]  off_q;
	logic [SB_W-1:0]   sb_q;

	// History memory: valid bit on top of the pattern.
	logic [PAT_W:0]   hist_mem [HIST_ENTRIES];
	logic [PAT_W:0]   rd_q;
	logic [HIST_AW-1:0] clr_q;
	logic             mem_we;
	logic [HIST_AW-1:0] mem_waddr;
	logic [PAT_W:0]   mem_wdata;

	// Record table.
	logic [KEY_W-1:0]   rec_key   [RECORD_ENTRIES];
	logic [PAT_W-1:0]   rec_pat   [RECORD_ENTRIES];
	logic [HIST_AW-1:0] rec_slot  [RECORD_ENTRIES];
	logic [RECORD_ENTRIES-1:0] rec_valid_q;

	// Walkers and results.
	logic [PAT_W-1:0] pat_q;
	logic [SB_W-1:0]  lpos_q, rpos_q;
	logic             l_act_q, r_act_q, l_miss_q, r_miss_q;
	logic [CNT_W-1:0] l_cnt_q, r_cnt_q;
	logic [CNT_W-1:0] res_left_q, res_right_q;
	logic [1:0]       res_out_q;

	logic [N_W-1:0]   n;
	logic [PAT_W-1:0] mask;
	logic [PAT_W-1:0] pat_m;
	logic             sb_ok;
	logic [KEY_W-1:0] key;
	logic [HIST_AW-1:0] slot;
	logic [PAT_W+OFF_W-1:0] idx_mix;
	logic             hit, free;
	logic [RW-1:0]    hit_idx, free_idx, sel;
	logic [PAT_W-1:0] sb_bit;
	logic             l_bit, r_bit, l_stop, r_stop;

	assign n = (cfg.subblocks_in_use > N_W'(MAX_SB)) ? N_W'(MAX_SB) : cfg.subblocks_in_use;
	assign mask = (n >= N_W'(PAT_W)) ? {PAT_W{1'b1}} : ((PAT_W'(1) << n[5:0]) - PAT_W'(1));
	assign pat_m = rd_q[PAT_W-1:0] & mask;
	assign sb_ok = {1'b0, sb_q} < n;
	assign key = {addr_q, off_q};
	assign idx_mix = (PAT_W+OFF_W)'(addr_q) ^ ((PAT_W+OFF_W)'(off_q) << IDX_SHIFT);
	assign slot = idx_mix[HIST_AW-1:0];
	assign sb_bit = sb_ok ? (PAT_W'(1) << sb_q) : '0;

	always_comb begin
		hit = 1'b0;
		free = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = RECORD_ENTRIES - 1; i >= 0; i--) begin
			if (rec_valid_q[i] && rec_key[i] == key) begin
				hit = 1'b1;
				hit_idx = RW'(i);
			end
			if (!rec_valid_q[i]) begin
				free = 1'b1;
				free_idx = RW'(i);
			end
		end
		sel = hit ? hit_idx : free_idx;
	end

	// One memory write port shared by the clearing pass and commits.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (cmd.clear_step) begin
			mem_we = 1'b1;
		end else if (cmd.exec && mode_q == MODE_COMMIT && hit) begin
			mem_we = 1'b1;
			mem_waddr = rec_slot[hit_idx];
			mem_wdata = {1'b1, rec_pat[hit_idx]};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
		if (cmd.mem_rd) rd_q <= hist_mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear_step) clr_q <= clr_q + HIST_AW'(1);
	end

	assign status.clear_last = (clr_q == HIST_AW'(HIST_ENTRIES - 1));
	assign status.mode_predict = (mode_q == MODE_PREDICT);
	assign status.usable = rd_q[PAT_W] && (pat_m != '0) && sb_ok;
	assign status.walk_done = !l_act_q && !r_act_q;

	assign l_bit = pat_q[lpos_q];
	assign r_bit = pat_q[rpos_q];
	assign l_stop = !l_bit && (!cfg.run_rule || l_miss_q);
	assign r_stop = !r_bit && (!cfg.run_rule || r_miss_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= in_mode;
			addr_q <= in_data[ADDR_W-1:0];
			off_q <= in_data[ADDR_W +: OFF_W];
			sb_q <= in_data[ADDR_W+OFF_W +: SB_W];
		end
		if (cmd.setup) begin
			pat_q <= pat_m;
			lpos_q <= sb_q - SB_W'(1);
			rpos_q <= sb_q + SB_W'(1);
			l_act_q <= (sb_q != '0);
			r_act_q <= ({1'b0, sb_q} + N_W'(1)) < n;
			l_miss_q <= 1'b0;
			r_miss_q <= 1'b0;
			l_cnt_q <= '0;
			r_cnt_q <= '0;
			res_left_q <= cfg.fallback_left;
			res_right_q <= cfg.fallback_right;
			res_out_q <= OUT_DONE;
		end
		if (cmd.walk) begin
			if (l_act_q) begin
				if (l_bit) l_cnt_q <= l_cnt_q + CNT_W'(1);
				else l_miss_q <= 1'b1;
				l_act_q <= !l_stop && (lpos_q != '0);
				lpos_q <= lpos_q - SB_W'(1);
			end
			if (r_act_q) begin
				if (r_bit) r_cnt_q <= r_cnt_q + CNT_W'(1);
				else r_miss_q <= 1'b1;
				r_act_q <= !r_stop && (({1'b0, rpos_q} + N_W'(1)) < n);
				rpos_q <= rpos_q + SB_W'(1);
			end
			if (!l_act_q && !r_act_q) begin
				res_left_q <= l_cnt_q;
				res_right_q <= r_cnt_q;
			end
		end
		if (cmd.exec) begin
			res_left_q <= '0;
			res_right_q <= '0;
			res_out_q <= OUT_DONE;
			case (mode_q)
				MODE_RECORD: begin
					if (hit || free) begin
						if (!hit) begin
							rec_key[sel] <= key;
							rec_pat[sel] <= sb_bit;
						end else begin
							rec_pat[sel] <= rec_pat[sel] | sb_bit;
						end
						rec_slot[sel] <= slot;
					end else begin
						res_out_q <= OUT_FULL;
					end
				end
				MODE_COMMIT: begin
					if (!hit) res_out_q <= OUT_NOREC;
				end
				default: res_out_q <= OUT_DONE;
			endcase
		end
		if (cmd.load_out) begin
			out_data <= {2'b00, res_out_q, res_right_q, res_left_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= '0;
		end else if (cmd.exec) begin
			if (mode_q == MODE_RECORD && !hit && free) rec_valid_q[free_idx] <= 1'b1;
			if (mode_q == MODE_COMMIT && hit) rec_valid_q[hit_idx] <= 1'b0;
		end
	end

endmodule

// ----- src/spatial_pattern_width_predictor_top.sv -----
// Top level of the spatial pattern width predictor: ports, configuration and units.
// Steps: a record, commit or idle word passes the read, execute and done states;
// a prediction passes read, setup and done with the fallback widths, else read, setup,
// the run walk, one pattern bit per cycle on each side (at most 63 bits), and done.
// Throughput: one word at a time; the bit-serial run walk sets the prediction time.
// Reset clears control state and then sweeps the 1024-entry history memory,
// during which no word is accepted; configuration is taken throughout.
module spatial_pattern_width_predictor_top import swpp_pkg::*; #(
	parameter int RECORD_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // block_address, trigger_offset, subblock_number
	input  logic [1:0]            s_tuser,  // mode
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // left_width, right_width, outcome
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_AW-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;
	logic    cfg_we;
	reg_idx_t cfg_idx;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	// Registers sit on word boundaries; the low address bits are ignored.
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.subblocks_in_use <= N_W'(8);
			cfg_q.fallback_left <= '0;
			cfg_q.fallback_right <= '0;
			cfg_q.run_rule <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SUBBLOCKS: cfg_q.subblocks_in_use <= pwdata[N_W-1:0];
				REG_FB_LEFT:   cfg_q.fallback_left <= pwdata[CNT_W-1:0];
				REG_FB_RIGHT:  cfg_q.fallback_right <= pwdata[CNT_W-1:0];
				REG_RUN_RULE:  cfg_q.run_rule <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read data is returned combinationally from the selected register.
	always_comb begin
		case (cfg_idx)
			REG_SUBBLOCKS: prdata = 32'(cfg_q.subblocks_in_use);
			REG_FB_LEFT:   prdata = 32'(cfg_q.fallback_left);
			REG_FB_RIGHT:  prdata = 32'(cfg_q.fallback_right);
			REG_RUN_RULE:  prdata = 32'(cfg_q.run_rule);
			default:       prdata = '0;
		endcase
	end

	swpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	swpp_dp #(
		.RECORD_ENTRIES (RECORD_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.in_mode  (s_tuser),
		.in_data  (s_tdata),
		.status   (status),
		.out_data (m_tdata)
	);

endmodule

// ----- sim/spatial_pattern_width_predictor_checker.sv -----
// Checker for the spatial pattern width predictor: predicts every result word and compares.
`timescale 1ns / 1ps
module spatial_pattern_width_predictor_checker import swpp_pkg::*; #(
	parameter int RECORD_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_AW-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		outcome_t         outcome;
		logic [CNT_W-1:0] right;
		logic [CNT_W-1:0] left;
	} width_result_t;

	logic [PAT_W-1:0]   hist_pat [HIST_ENTRIES];
	logic               hist_ok [HIST_ENTRIES];
	logic [KEY_W-1:0]   rec_key [RECORD_ENTRIES];
	logic [PAT_W-1:0]   rec_pat [RECORD_ENTRIES];
	logic [HIST_AW-1:0] rec_slot [RECORD_ENTRIES];
	logic               rec_ok [RECORD_ENTRIES];
	cfg_t               cfg;
	width_result_t      expected_widths [$];

	assign pending = expected_widths.size();

	function automatic logic [CNT_W-1:0] count_run(logic [PAT_W-1:0] pat, int start, int dir,
			int n);
		int count;
		int misses;
		int i;
		count = 0;
		misses = 0;
		for (i = start; i >= 0 && i < n; i += dir) begin
			if (pat[i]) begin
				count++;
			end else begin
				misses++;
				if (!cfg.run_rule || misses == 2) break;
			end
		end
		return count[CNT_W-1:0];
	endfunction

	// Applies one accepted word to the shadow tables and returns its result.
	function automatic width_result_t predict_widths(mode_t mode, logic [ADDR_W-1:0] addr,
			logic [OFF_W-1:0] off, logic [SB_W-1:0] sb);
		width_result_t res;
		int n;
		int r;
		logic [PAT_W-1:0] pat;
		logic [PAT_W-1:0] mask;
		logic [KEY_W-1:0] key;
		logic [HIST_AW-1:0] slot;
		res = '0;
		n = (cfg.subblocks_in_use > MAX_SB) ? MAX_SB : cfg.subblocks_in_use;
		mask = (n >= PAT_W) ? '1 : ((64'd1 << n) - 64'd1);
		key = {addr, off};
		slot = HIST_AW'(addr ^ (ADDR_W'(off) << IDX_SHIFT));
		r = -1;
		for (int i = 0; i < RECORD_ENTRIES; i++)
			if (r < 0 && rec_ok[i] && rec_key[i] == key) r = i;
		case (mode)
			MODE_PREDICT: begin
				pat = hist_pat[slot] & mask;
				if (!hist_ok[slot] || pat == '0 || sb >= n) begin
					res.left = cfg.fallback_left;
					res.right = cfg.fallback_right;
				end else begin
					res.left = count_run(pat, int'(sb) - 1, -1, n);
					res.right = count_run(pat, int'(sb) + 1, 1, n);
				end
			end
			MODE_RECORD: begin
				if (r < 0) begin
					for (int i = 0; i < RECORD_ENTRIES; i++) begin
						if (r < 0 && !rec_ok[i]) begin
							r = i;
							rec_pat[i] = '0;
							rec_key[i] = key;
							rec_ok[i] = 1'b1;
						end
					end
				end
				if (r < 0) begin
					res.outcome = OUT_FULL;
				end else begin
					if (sb < n) rec_pat[r][sb] = 1'b1;
					rec_slot[r] = slot;
				end
			end
			MODE_COMMIT: begin
				if (r < 0) begin
					res.outcome = OUT_NOREC;
				end else begin
					hist_pat[rec_slot[r]] = rec_pat[r];
					hist_ok[rec_slot[r]] = 1'b1;
					rec_ok[r] = 1'b0;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		width_result_t got;
		width_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < HIST_ENTRIES; i++) begin
				hist_pat[i] = '0;
				hist_ok[i] = 1'b0;
			end
			for (int i = 0; i < RECORD_ENTRIES; i++) rec_ok[i] = 1'b0;
			cfg = '{subblocks_in_use: 7'd8, default: '0};
			expected_widths.delete();
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(width_result_t)-1:0];
				if (expected_widths.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word %h", $time, m_tdata);
				end else begin
					want = expected_widths.pop_front();
					if (got.left !== want.left || got.right !== want.right
							|| got.outcome !== want.outcome) begin
						errors++;
						$display("%0t: result mismatch, expected left %0d right %0d outcome %0d",
							$time, want.left, want.right, want.outcome,
							", got left %0d right %0d outcome %0d",
							got.left, got.right, got.outcome);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_widths.push_back(predict_widths(mode_t'(s_tuser),
					s_tdata[ADDR_W-1:0], s_tdata[ADDR_W +: OFF_W],
					s_tdata[ADDR_W+OFF_W +: SB_W]));
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_SUBBLOCKS: cfg.subblocks_in_use = pwdata[N_W-1:0];
					REG_FB_LEFT:   cfg.fallback_left = pwdata[CNT_W-1:0];
					REG_FB_RIGHT:  cfg.fallback_right = pwdata[CNT_W-1:0];
					REG_RUN_RULE:  cfg.run_rule = pwdata[0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- sim/spatial_pattern_width_predictor_top_tb.sv -----
// Testbench top for the spatial pattern width predictor: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module spatial_pattern_width_predictor_top_tb;
	import swpp_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;  // block_address, trigger_offset, subblock_number
	logic [1:0]            s_tuser = '0;  // mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;       // left_width, right_width, outcome
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_AW-1:0]     paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	int                    errors;
	int                    pending;
	int                    send_idle_pct;
	int                    recv_idle_pct;

	always #10 clk = ~clk;

	spatial_pattern_width_predictor_top uut (.*);
	spatial_pattern_width_predictor_checker checker_i (.*);

	// The receiver stalls at random; the stall rate is changed between phases.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Sends one word after a random gap and holds it until the block takes it.
	// The valid is dropped after acceptance, while the block is still busy
	// with the word.
	task automatic send_word(mode_t mode, logic [ADDR_W-1:0] addr, logic [OFF_W-1:0] off,
			logic [SB_W-1:0] sb);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= IN_DATA_W'({sb, off, addr});
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for every expected word, then for the longest prediction walk so
	// that nothing is still in flight when the configuration changes.
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// A generation: several accesses to one region, usually a commit, then predictions
	// around it. Addresses mostly come from a small pool so that keys and slots meet.
	task automatic run_generation(int accesses);
		logic [ADDR_W-1:0] addr;
		logic [OFF_W-1:0] off;
		addr = ADDR_W'({$urandom, $urandom}) & ($urandom_range(3) == 0 ? '1 : 48'h3F);
		off = OFF_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(3));
		for (int i = 0; i < accesses; i++)
			send_word(MODE_RECORD, addr, off,
				SB_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(15)));
		if ($urandom_range(9) != 0) send_word(MODE_COMMIT, addr, off, SB_W'($urandom));
		for (int i = 0; i < 3; i++)
			send_word(MODE_PREDICT, addr, off,
				SB_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(15)));
	endtask

	initial begin
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty table, records, commit, extremes and the full table.
		write_reg(REG_FB_LEFT, 32'd63);
		write_reg(REG_FB_RIGHT, 32'd5);
		send_word(MODE_PREDICT, '0, '0, '0);
		send_word(MODE_COMMIT, '1, '1, '1);
		send_word(MODE_NOP, '1, '1, '1);
		for (int sb = 0; sb < 8; sb += 2) send_word(MODE_RECORD, '1, '1, sb[SB_W-1:0]);
		send_word(MODE_RECORD, '1, '1, 6'd63);
		send_word(MODE_COMMIT, '1, '1, '0);
		send_word(MODE_PREDICT, '1, '1, 6'd4);
		send_word(MODE_PREDICT, '1, '1, 6'd63);
		for (int i = 0; i < 17; i++) send_word(MODE_RECORD, ADDR_W'(i), 12'd7, 6'd1);
		drain();
		write_reg(REG_RUN_RULE, 32'd1);
		send_word(MODE_PREDICT, '1, '1, 6'd0);
		send_word(MODE_PREDICT, '1, '1, 6'd7);
		for (int i = 0; i < 16; i++) send_word(MODE_COMMIT, ADDR_W'(i), 12'd7, 6'd0);
		drain();

		// Random part in three idling phases, each over several settings.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 74 : 0;
			recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 8 : 0;
			for (int setting = 0; setting < 4; setting++) begin
				drain();
				case (setting)
					0: write_reg(REG_SUBBLOCKS, 32'd64);
					1: write_reg(REG_SUBBLOCKS, 32'd1);
					2: write_reg(REG_SUBBLOCKS, 32'd127);
					default: write_reg(REG_SUBBLOCKS, $urandom_range(2, 20));
				endcase
				write_reg(REG_FB_LEFT, $urandom_range(63));
				write_reg(REG_FB_RIGHT, $urandom_range(63));
				write_reg(REG_RUN_RULE, $urandom_range(1));
				for (int g = 0; g < 15; g++) begin
					if ($urandom_range(5) == 0) begin
						send_word(mode_t'(2'($urandom)), ADDR_W'({$urandom, $urandom}),
							OFF_W'($urandom), SB_W'($urandom));
					end else begin
						run_generation($urandom_range(1, 6));
					end
				end
			end
		end
		drain();
		if (errors == 0)
			$display("spatial_pattern_width_predictor_top_tb: PASS");
		else
			$display("spatial_pattern_width_predictor_top_tb: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("spatial_pattern_width_predictor_top_tb: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
src/swpp_pkg.sv
src/swpp_ctrl.sv
src/swpp_dp.sv
src/spatial_pattern_width_predictor_top.sv
sim/spatial_pattern_width_predictor_checker.sv
sim/spatial_pattern_width_predictor_top_tb.sv
